// ===== sv/erc_pkg.sv =====
// ----------------------------------------------------------------------------
// erc_pkg: shared types and constants of the extent run coalescer
// Register indexes, the configuration word and the per-item flag group.
// ----------------------------------------------------------------------------
package erc_pkg;

  localparam int OFFSET_BITS_DEF = 48;
  localparam int QUEUE_DEPTH     = 4;
  localparam int CFG_INDEX_BITS  = 2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IGNORE_LOADED    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IGNORE_MODIFIED  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEFAULT_LOADED   = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEFAULT_MODIFIED = 2'd3;

  typedef struct packed {
    logic ignore_loaded;
    logic ignore_modified;
    logic default_loaded;
    logic default_modified;
  } cfg_t;

  // Classification of one queued extent; ignored flags are already forced to their defaults
  typedef struct packed {
    logic zero_len;
    logic loaded;
    logic modified;
    logic last;
  } item_flags_t;

endpackage

// ===== sv/extent_run_coalescer_unit.sv =====
// ----------------------------------------------------------------------------
// extent_run_coalescer_unit: byte extent run coalescer
// Merges an ascending list of byte extents into runs of equal flags.
// ----------------------------------------------------------------------------
//
//  channel | signals                                      | role
//  --------+----------------------------------------------+------------------
//  in      | in_valid/in_ready, start_offset,             | extents, ascending
//          | extent_length, ext_loaded, ext_modified,     | offset order
//          | end_of_list                                  |
//  out     | out_valid/out_ready, out_offset, out_length, | merged extents
//          | out_loaded, out_modified, out_last           |
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data     | register writes
//
//  Cycles: one extent per cycle while the output is not stalled and each
//  extent yields at most one result; an extent that yields k results (k up
//  to 3) holds the back end while the single output register, loaded once per
//  cycle, takes them. Each extent passes the queue, then the output register.
//  Reset clears the queue, the pending extent, the output valid flag and all
//  configuration registers; no clearing pass is needed.
//  A stalled output holds the back end; the 4-entry queue keeps taking input
//  until full, after which in_ready drops.
//
module extent_run_coalescer_unit #(
  parameter int OFFSET_BITS = erc_pkg::OFFSET_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // input extents
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [OFFSET_BITS-1:0]             start_offset,
  input  logic [OFFSET_BITS-1:0]             extent_length,
  input  logic                               ext_loaded,
  input  logic                               ext_modified,
  input  logic                               end_of_list,
  // merged extents
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [OFFSET_BITS-1:0]             out_offset,
  output logic [OFFSET_BITS-1:0]             out_length,
  output logic                               out_loaded,
  output logic                               out_modified,
  output logic                               out_last,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [erc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic                               cfg_data
);
  import erc_pkg::*;

  localparam int EntryW = 3 * OFFSET_BITS + 1 + $bits(item_flags_t);

  cfg_t                   cfg;
  logic                   q_full;
  logic                   q_push;
  logic                   q_pop;
  logic                   q_valid;
  logic [OFFSET_BITS-1:0] f_ofs;
  logic [OFFSET_BITS-1:0] f_len;
  logic [OFFSET_BITS:0]   f_end;
  item_flags_t            f_flags;
  logic [EntryW-1:0]      q_wdata;
  logic [EntryW-1:0]      q_rdata;
  logic [OFFSET_BITS-1:0] b_ofs;
  logic [OFFSET_BITS-1:0] b_len;
  logic [OFFSET_BITS:0]   b_end;
  item_flags_t            b_flags;

  // Registers are always writable; the user writes only while the block is idle (unenforced)
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IGNORE_LOADED:    cfg.ignore_loaded    <= cfg_data;
        CFG_IGNORE_MODIFIED:  cfg.ignore_modified  <= cfg_data;
        CFG_DEFAULT_LOADED:   cfg.default_loaded   <= cfg_data;
        CFG_DEFAULT_MODIFIED: cfg.default_modified <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: accept and classify each extent
  erc_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .start_offset  (start_offset),
    .extent_length (extent_length),
    .ext_loaded    (ext_loaded),
    .ext_modified  (ext_modified),
    .end_of_list   (end_of_list),
    .cfg           (cfg),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_ofs         (f_ofs),
    .q_len         (f_len),
    .q_end         (f_end),
    .q_flags       (f_flags)
  );

  // Pack the classified extent into one queue word
  assign q_wdata = {f_flags, f_end, f_len, f_ofs};

  erc_queue #(
    .DATA_W (EntryW),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_valid)
  );

  assign {b_flags, b_end, b_len, b_ofs} = q_rdata;

  // Back: merge, fill gaps, emit results one transfer per cycle while the output is not stalled
  erc_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .i_ofs        (b_ofs),
    .i_len        (b_len),
    .i_end        (b_end),
    .i_flags      (b_flags),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_offset   (out_offset),
    .out_length   (out_length),
    .out_loaded   (out_loaded),
    .out_modified (out_modified),
    .out_last     (out_last)
  );

endmodule

// ===== sv/erc_queue.sv =====
// ----------------------------------------------------------------------------
// erc_queue: short FIFO between front and back
// Holds classified extents so that either side can stall on its own.
// ----------------------------------------------------------------------------
module erc_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata,
  output logic              not_empty
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;

  assign full      = (count == CntW'(DEPTH));
  assign not_empty = (count != '0);
  assign rdata     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CntW'(push) - CntW'(pop);
    end
  end

endmodule

// ===== sv/erc_front.sv =====
// ----------------------------------------------------------------------------
// erc_front: input side of the coalescer
// Accept extents, force ignored flags, mark zero length and form the end.
// ----------------------------------------------------------------------------
module erc_front #(
  parameter int OFFSET_BITS = 48
) (
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [OFFSET_BITS-1:0] start_offset,
  input  logic [OFFSET_BITS-1:0] extent_length,
  input  logic                   ext_loaded,
  input  logic                   ext_modified,
  input  logic                   end_of_list,
  input  erc_pkg::cfg_t          cfg,
  input  logic                   q_full,
  output logic                   q_push,
  output logic [OFFSET_BITS-1:0] q_ofs,
  output logic [OFFSET_BITS-1:0] q_len,
  output logic [OFFSET_BITS:0]   q_end,
  output erc_pkg::item_flags_t   q_flags
);
  import erc_pkg::*;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign q_ofs    = start_offset;
  assign q_len    = extent_length;
  // End of the extent, one bit wider so that it never wraps
  assign q_end    = {1'b0, start_offset} + {1'b0, extent_length};

  always_comb begin
    q_flags.zero_len = (extent_length == '0);
    q_flags.loaded   = cfg.ignore_loaded ? cfg.default_loaded : ext_loaded;
    q_flags.modified = cfg.ignore_modified ? cfg.default_modified : ext_modified;
    q_flags.last     = end_of_list;
  end

endmodule

// ===== sv/erc_back.sv =====
// ----------------------------------------------------------------------------
// erc_back: coalescing engine
// Hold the pending extent, merge, fill gaps and drive the output register.
// ----------------------------------------------------------------------------
module erc_back #(
  parameter int OFFSET_BITS = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  erc_pkg::cfg_t          cfg,
  input  logic                   q_valid,
  input  logic [OFFSET_BITS-1:0] i_ofs,
  input  logic [OFFSET_BITS-1:0] i_len,
  input  logic [OFFSET_BITS:0]   i_end,
  input  erc_pkg::item_flags_t   i_flags,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OFFSET_BITS-1:0] out_offset,
  output logic [OFFSET_BITS-1:0] out_length,
  output logic                   out_loaded,
  output logic                   out_modified,
  output logic                   out_last
);
  import erc_pkg::*;

  localparam logic [OFFSET_BITS-1:0] LenMax = {OFFSET_BITS{1'b1}};

  // Pending extent; pend_end is offset plus length, kept unwrapped
  logic                   pend_valid;
  logic [OFFSET_BITS-1:0] pend_ofs;
  logic [OFFSET_BITS-1:0] pend_len;
  logic [OFFSET_BITS:0]   pend_end;
  logic                   pend_ld;
  logic                   pend_md;

  logic                   pend_valid_next;
  logic [OFFSET_BITS-1:0] pend_ofs_next;
  logic [OFFSET_BITS-1:0] pend_len_next;
  logic [OFFSET_BITS:0]   pend_end_next;
  logic                   pend_ld_next;
  logic                   pend_md_next;

  logic                   emit;
  logic [OFFSET_BITS-1:0] e_ofs;
  logic [OFFSET_BITS-1:0] e_len;
  logic                   e_ld;
  logic                   e_md;
  logic                   e_last;
  logic                   done;

  logic                   step;
  logic [OFFSET_BITS:0]   ofs_x;
  logic                   overlap;
  logic                   gap;
  logic                   hot;
  logic                   differ;
  logic [OFFSET_BITS-1:0] stretch_len;
  logic [OFFSET_BITS-1:0] gap_len;
  logic [OFFSET_BITS:0]   merge_raw;
  logic [OFFSET_BITS-1:0] merge_len;
  logic [OFFSET_BITS:0]   merge_end;
  logic [OFFSET_BITS:0]   sat_end;

  assign step  = q_valid && (!out_valid || out_ready);
  assign q_pop = step && done;

  assign ofs_x       = {1'b0, i_ofs};
  assign overlap     = pend_valid && (ofs_x < pend_end);
  assign gap         = pend_valid && (ofs_x > pend_end);
  assign hot         = (!cfg.ignore_loaded && pend_ld) || (!cfg.ignore_modified && pend_md);
  assign differ      = (pend_ld != i_flags.loaded) || (pend_md != i_flags.modified);
  assign stretch_len = i_ofs - pend_ofs;
  assign gap_len     = i_ofs - pend_end[OFFSET_BITS-1:0];
  assign merge_raw   = i_end - {1'b0, pend_ofs};
  assign sat_end     = {1'b0, pend_ofs} + {1'b0, LenMax};
  assign merge_len   = merge_raw[OFFSET_BITS] ? LenMax : merge_raw[OFFSET_BITS-1:0];
  assign merge_end   = merge_raw[OFFSET_BITS] ? sat_end : i_end;

  // One evaluation per cycle, unless the output stalls, against the pending
  // extent. An item that needs more than one result stays at the queue head and
  // is looked at again; the state it left makes the repeat pick up the next result.
  always_comb begin
    pend_valid_next = pend_valid;
    pend_ofs_next   = pend_ofs;
    pend_len_next   = pend_len;
    pend_end_next   = pend_end;
    pend_ld_next    = pend_ld;
    pend_md_next    = pend_md;
    emit            = 1'b0;
    e_ofs           = pend_ofs;
    e_len           = pend_len;
    e_ld            = pend_ld;
    e_md            = pend_md;
    e_last          = 1'b0;
    done            = 1'b1;

    if (!i_flags.zero_len && !overlap) begin
      if (!pend_valid || (differ && !(gap && hot))) begin
        if (pend_valid) begin
          emit  = 1'b1;
          e_len = gap ? stretch_len : pend_len;
        end
        pend_valid_next = 1'b1;
        pend_ofs_next   = i_ofs;
        pend_len_next   = i_len;
        pend_end_next   = i_end;
        pend_ld_next    = i_flags.loaded;
        pend_md_next    = i_flags.modified;
      end else if (gap && hot) begin
        // Close the pending extent and fill the hole with one whose flags are clear or the configured defaults
        emit          = 1'b1;
        done          = 1'b0;
        pend_ofs_next = pend_end[OFFSET_BITS-1:0];
        pend_len_next = gap_len;
        pend_end_next = ofs_x;
        pend_ld_next  = cfg.ignore_loaded ? cfg.default_loaded : 1'b0;
        pend_md_next  = cfg.ignore_modified ? cfg.default_modified : 1'b0;
      end else begin
        pend_len_next = merge_len;
        pend_end_next = merge_end;
      end
    end

    if (i_flags.last) begin
      if (emit) begin
        done = 1'b0;
      end else begin
        emit            = 1'b1;
        e_last          = 1'b1;
        e_ofs           = pend_valid_next ? pend_ofs_next : '0;
        e_len           = pend_valid_next ? pend_len_next : '0;
        e_ld            = pend_valid_next ? pend_ld_next : 1'b0;
        e_md            = pend_valid_next ? pend_md_next : 1'b0;
        pend_valid_next = 1'b0;
        pend_ofs_next   = '0;
        pend_len_next   = '0;
        pend_end_next   = '0;
        pend_ld_next    = 1'b0;
        pend_md_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      pend_ofs   <= '0;
      pend_len   <= '0;
      pend_end   <= '0;
      pend_ld    <= 1'b0;
      pend_md    <= 1'b0;
      out_valid  <= 1'b0;
    end else if (step) begin
      pend_valid <= pend_valid_next;
      pend_ofs   <= pend_ofs_next;
      pend_len   <= pend_len_next;
      pend_end   <= pend_end_next;
      pend_ld    <= pend_ld_next;
      pend_md    <= pend_md_next;
      out_valid  <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_offset   <= e_ofs;
      out_length   <= e_len;
      out_loaded   <= e_ld;
      out_modified <= e_md;
      out_last     <= e_last;
    end
  end

endmodule

// ===== sv/erc_checker.sv =====
// ----------------------------------------------------------------------------
// erc_checker: port-level checks of the extent run coalescer
// Watch output handshake, end marker form and run contiguity.
// ----------------------------------------------------------------------------
module erc_checker #(
  parameter int OFFSET_BITS = 48
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [OFFSET_BITS-1:0] out_offset,
  input logic [OFFSET_BITS-1:0] out_length,
  input logic                   out_loaded,
  input logic                   out_modified,
  input logic                   out_last
);
  logic                 prev_open;
  logic [OFFSET_BITS:0] prev_end;
  logic                 out_xfer;

  assign out_xfer = out_valid && out_ready;

  // Track end of the last transferred result within an open list
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_open <= 1'b0;
      prev_end  <= '0;
    end else if (out_xfer) begin
      prev_open <= !out_last;
      prev_end  <= {1'b0, out_offset} + {1'b0, out_length};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_offset) &&
    $stable(out_length) && $stable(out_last))
    else $error("output changed while stalled");

  a_out_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(out_ready))
    else $error("output valid dropped without transfer");

  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_length == '0) |->
    out_last && (out_offset == '0) && !out_loaded && !out_modified)
    else $error("zero length result that is not an end marker");

  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    out_xfer && prev_open |-> ({1'b0, out_offset} == prev_end))
    else $error("results of one list are not contiguous");

endmodule

bind extent_run_coalescer_unit erc_checker #(
  .OFFSET_BITS (OFFSET_BITS)
) u_erc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_offset   (out_offset),
  .out_length   (out_length),
  .out_loaded   (out_loaded),
  .out_modified (out_modified),
  .out_last     (out_last)
);
